### design/gnp_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// gnp_pkg: shared types and constants for the gradient noise pixel block
// Grid size, fixed-point widths, request structs and the quintic fade table.
// ---------------------------------------------------------------------------
package gnp_pkg;

	// lattice size in cells
	localparam int GRID_COLS = 16;
	localparam int GRID_ROWS = 16;

	// cell index widths (cells 0..GRID-1)
	localparam int CELL_CW = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
	localparam int CELL_RW = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;

	// corner store split into four parity banks
	localparam int BANK_COLS  = GRID_COLS / 2 + 1;
	localparam int BANK_ROWS  = GRID_ROWS / 2 + 1;
	localparam int BANK_DEPTH = BANK_COLS * BANK_ROWS;
	localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

	// port widths
	localparam int PIX_W    = 12;
	localparam int CORNER_W = 5;
	localparam int CFG_W    = 4;
	localparam int NOISE_W  = 16;

	// fixed point
	localparam int FRAC_W  = 14;
	localparam int T_W     = 8;
	localparam int FADE_W  = 15;
	localparam int DOT_W   = 18;
	localparam int ONE_Q14 = 16384;

	localparam logic [CFG_W-1:0] CELL_LOG2_RESET = 4'd6;
	localparam logic [CFG_W-1:0] CELL_LOG2_MIN   = 4'd1;
	localparam logic [CFG_W-1:0] CELL_LOG2_MAX   = 4'd8;

	typedef enum logic {
		KIND_PIXEL = 1'b0,
		KIND_WRITE = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		GRAD_PP = 2'd0,
		GRAD_NP = 2'd1,
		GRAD_NN = 2'd2,
		GRAD_PN = 2'd3
	} grad_t;

	// gradient write request into the corner store
	typedef struct packed {
		logic                en;
		logic [CORNER_W-1:0] col;
		logic [CORNER_W-1:0] row;
		logic [1:0]          code;
	} grad_wr_t;

	// cell whose four corners are read
	typedef struct packed {
		logic [CELL_CW-1:0] cx;
		logic [CELL_RW-1:0] cy;
	} cell_rd_t;

	typedef logic [(1 << T_W)-1:0][FADE_W-1:0] fade_lut_t;

	// fade of t = k/256, rounded half up to Q1.14
	function automatic fade_lut_t fade_lut_build();
		fade_lut_t   lut;
		logic [63:0] kk;
		logic [63:0] poly;
		logic [63:0] num;
		logic [63:0] r;
		for (int k = 0; k < (1 << T_W); k++) begin
			kk   = 64'(k);
			poly = 64'd6 * kk * kk + 64'd655360 - 64'd3840 * kk;
			num  = kk * kk * kk * poly;
			r    = ((num << FRAC_W) + (64'd1 << 39)) >> 40;
			lut[k] = r[FADE_W-1:0];
		end
		return lut;
	endfunction

	localparam fade_lut_t FADE_LUT = fade_lut_build();

endpackage
`default_nettype wire

### design/gnp_grad_store.sv
`default_nettype none
// ---------------------------------------------------------------------------
// gnp_grad_store: corner gradient store
// Four banks split by corner column and row parity, so the four corners of
// one cell are read in the same cycle, one read per bank. Read data is registered.
// ---------------------------------------------------------------------------
module gnp_grad_store (
	input  wire logic                  clk,
	input  wire gnp_pkg::grad_wr_t     wr,
	input  wire gnp_pkg::cell_rd_t     rd,
	output logic [3:0][1:0]            bank_code_s2
);
	import gnp_pkg::*;

	logic                wr_ok;
	logic [1:0]          wr_bank;
	logic [BANK_AW-1:0]  wr_addr;

	// decode the write request; drop corners outside the grid
	always_comb begin
		wr_ok   = wr.en && (int'(wr.col) <= GRID_COLS) && (int'(wr.row) <= GRID_ROWS);
		wr_bank = {wr.row[0], wr.col[0]};
		wr_addr = BANK_AW'(int'(wr.row[CORNER_W-1:1]) * BANK_COLS
			+ int'(wr.col[CORNER_W-1:1]));
	end

	for (genvar b = 0; b < 4; b++) begin : g_bank
		localparam logic CP = 1'(b % 2);
		localparam logic RP = 1'(b / 2);

		logic [1:0]         mem [BANK_DEPTH];
		logic [CELL_CW:0]   col_c;
		logic [CELL_RW:0]   row_c;
		logic [BANK_AW-1:0] rd_addr;

		// pick the corner of this parity next to the cell
		always_comb begin
			col_c   = {1'b0, rd.cx} + (CELL_CW+1)'(rd.cx[0] ^ CP);
			row_c   = {1'b0, rd.cy} + (CELL_RW+1)'(rd.cy[0] ^ RP);
			rd_addr = BANK_AW'(int'(row_c[CELL_RW:1]) * BANK_COLS + int'(col_c[CELL_CW:1]));
		end

		// write one corner
		always_ff @(posedge clk) begin
			if (wr_ok && wr_bank == 2'(b)) begin
				mem[wr_addr] <= wr.code;
			end
		end

		// registered read
		always_ff @(posedge clk) begin
			bank_code_s2[b] <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

### design/gradient_noise_pixel.sv
`default_nettype none
// ---------------------------------------------------------------------------
// gradient_noise_pixel: 2D gradient noise, one pixel per request
// Result: done goes high once a pixel request has passed stages 1 to 6 and
//   the output register; gradient writes give no result.
// Throughput: one request per clock; busy stays low, as the seven-stage
//   pipeline and the four-bank corner store take a request every cycle.
// Reset: arst_n clears the stage valid bits and sets cell_log2 to 6; the
//   gradient store is not cleared and must be loaded before any pixel.
// ---------------------------------------------------------------------------
module gradient_noise_pixel (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output logic                                busy,
	input  wire logic                           kind,
	input  wire logic [gnp_pkg::PIX_W-1:0]      pixel_x,
	input  wire logic [gnp_pkg::PIX_W-1:0]      pixel_y,
	input  wire logic [gnp_pkg::CORNER_W-1:0]   corner_col,
	input  wire logic [gnp_pkg::CORNER_W-1:0]   corner_row,
	input  wire logic [1:0]                     grad_code,
	input  wire logic                           cfg_write,
	input  wire logic [gnp_pkg::CFG_W-1:0]      cfg_data,
	output logic                                done,
	output logic signed [gnp_pkg::NOISE_W-1:0]  noise_value
);
	import gnp_pkg::*;

	// dot of a diagonal gradient with an offset vector
	function automatic logic signed [DOT_W-1:0] grad_dot(
		input logic [1:0]               code,
		input logic signed [DOT_W-1:0]  dx,
		input logic signed [DOT_W-1:0]  dy
	);
		logic signed [DOT_W-1:0] r;
		case (grad_t'(code))
			GRAD_PP: r = dx + dy;
			GRAD_NP: r = dy - dx;
			GRAD_NN: r = -dx - dy;
			GRAD_PN: r = dx - dy;
			default: r = dx + dy;
		endcase
		return r;
	endfunction

	logic [CFG_W-1:0] cell_log2_q;
	logic             accept;
	logic             pix_req;
	grad_wr_t         wr_req;

	// stage 0 (request cycle)
	logic [CFG_W-1:0]  l_eff;
	logic [CFG_W-1:0]  sh_up;
	logic [PIX_W-1:0]  px_up, py_up;
	logic [PIX_W-1:0]  px_cell, py_cell;
	cell_rd_t          cell_s0;

	// stage 1
	logic              valid_s1;
	logic [T_W-1:0]    kx_s1, ky_s1;
	cell_rd_t          cell_s1;

	// stage 2
	logic              valid_s2;
	logic [T_W-1:0]    kx_s2, ky_s2;
	logic [FADE_W-1:0] sx_s2, sy_s2;
	logic              cxp_s2, cyp_s2;
	logic [3:0][1:0]   bank_code_s2;
	logic signed [DOT_W-1:0] dx0, dx1, dy0, dy1;
	logic signed [DOT_W-1:0] d00, d10, d01, d11;

	// stage 3
	logic              valid_s3;
	logic signed [DOT_W-1:0] d00_s3, d10_s3, d01_s3, d11_s3;
	logic [FADE_W-1:0] sx_s3, sy_s3;
	logic signed [DOT_W:0]   diff0, diff1;
	logic signed [34:0]      prod0, prod1;

	// stage 4
	logic              valid_s4;
	logic signed [34:0]      prod0_s4, prod1_s4;
	logic signed [DOT_W-1:0] a0_s4, a1_s4;
	logic [FADE_W-1:0] sy_s4;
	logic signed [34:0]      sum0, sum1;

	// stage 5
	logic              valid_s5;
	logic signed [18:0]      x0_s5, x1_s5;
	logic [FADE_W-1:0] sy_s5;
	logic signed [19:0]      diffy;
	logic signed [35:0]      prody;

	// stage 6
	logic              valid_s6;
	logic signed [35:0]      prody_s6;
	logic signed [18:0]      x0_s6;
	logic signed [35:0]      v;
	logic signed [NOISE_W-1:0] v_sat;

	// output
	logic                      done_q;
	logic signed [NOISE_W-1:0] noise_q;

	assign busy    = 1'b0;
	assign accept  = start && !busy;
	assign pix_req = accept && (kind_t'(kind) == KIND_PIXEL);

	// hold the cell size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_log2_q <= CELL_LOG2_RESET;
		end else if (cfg_write) begin
			cell_log2_q <= cfg_data;
		end
	end

	// route gradient writes straight to the store
	always_comb begin
		wr_req.en   = accept && (kind_t'(kind) == KIND_WRITE);
		wr_req.col  = corner_col;
		wr_req.row  = corner_row;
		wr_req.code = grad_code;
	end

	// split coordinate into cell and fraction, clamp the cell
	always_comb begin
		if (cell_log2_q < CELL_LOG2_MIN) begin
			l_eff = CELL_LOG2_MIN;
		end else if (cell_log2_q > CELL_LOG2_MAX) begin
			l_eff = CELL_LOG2_MAX;
		end else begin
			l_eff = cell_log2_q;
		end
		sh_up   = CFG_W'(T_W) - l_eff;
		px_up   = pixel_x << sh_up;
		py_up   = pixel_y << sh_up;
		px_cell = pixel_x >> l_eff;
		py_cell = pixel_y >> l_eff;
		cell_s0.cx = (int'(px_cell) > GRID_COLS - 1) ? CELL_CW'(GRID_COLS - 1)
			: px_cell[CELL_CW-1:0];
		cell_s0.cy = (int'(py_cell) > GRID_ROWS - 1) ? CELL_RW'(GRID_ROWS - 1)
			: py_cell[CELL_RW-1:0];
	end

	// advance stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= pix_req;
		end
	end

	always_ff @(posedge clk) begin
		kx_s1   <= px_up[T_W-1:0];
		ky_s1   <= py_up[T_W-1:0];
		cell_s1 <= cell_s0;
	end

	gnp_grad_store u_store (
		.clk          (clk),
		.wr           (wr_req),
		.rd           (cell_s1),
		.bank_code_s2 (bank_code_s2)
	);

	// advance stage 2: fade lookup beside the corner read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		kx_s2  <= kx_s1;
		ky_s2  <= ky_s1;
		sx_s2  <= FADE_LUT[kx_s1];
		sy_s2  <= FADE_LUT[ky_s1];
		cxp_s2 <= cell_s1.cx[0];
		cyp_s2 <= cell_s1.cy[0];
	end

	// dot each corner gradient with its offset vector
	always_comb begin
		dx0 = $signed({{(DOT_W-T_W-(FRAC_W-T_W)){1'b0}}, kx_s2, {(FRAC_W-T_W){1'b0}}});
		dy0 = $signed({{(DOT_W-T_W-(FRAC_W-T_W)){1'b0}}, ky_s2, {(FRAC_W-T_W){1'b0}}});
		dx1 = dx0 - DOT_W'(ONE_Q14);
		dy1 = dy0 - DOT_W'(ONE_Q14);
		d00 = grad_dot(bank_code_s2[{cyp_s2, cxp_s2}], dx0, dy0);
		d10 = grad_dot(bank_code_s2[{cyp_s2, ~cxp_s2}], dx1, dy0);
		d01 = grad_dot(bank_code_s2[{~cyp_s2, cxp_s2}], dx0, dy1);
		d11 = grad_dot(bank_code_s2[{~cyp_s2, ~cxp_s2}], dx1, dy1);
	end

	// advance stage 3
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		d00_s3 <= d00;
		d10_s3 <= d10;
		d01_s3 <= d01;
		d11_s3 <= d11;
		sx_s3  <= sx_s2;
		sy_s3  <= sy_s2;
	end

	// scale the x differences by the x fade
	always_comb begin
		diff0 = {d10_s3[DOT_W-1], d10_s3} - {d00_s3[DOT_W-1], d00_s3};
		diff1 = {d11_s3[DOT_W-1], d11_s3} - {d01_s3[DOT_W-1], d01_s3};
		prod0 = $signed({1'b0, sx_s3}) * diff0;
		prod1 = $signed({1'b0, sx_s3}) * diff1;
	end

	// advance stage 4
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		prod0_s4 <= prod0;
		prod1_s4 <= prod1;
		a0_s4    <= d00_s3;
		a1_s4    <= d01_s3;
		sy_s4    <= sy_s3;
	end

	// round half up and add back to the left corner
	always_comb begin
		sum0 = {{(35-DOT_W){a0_s4[DOT_W-1]}}, a0_s4} + ((prod0_s4 + 35'sd8192) >>> FRAC_W);
		sum1 = {{(35-DOT_W){a1_s4[DOT_W-1]}}, a1_s4} + ((prod1_s4 + 35'sd8192) >>> FRAC_W);
	end

	// advance stage 5
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else begin
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		x0_s5 <= sum0[18:0];
		x1_s5 <= sum1[18:0];
		sy_s5 <= sy_s4;
	end

	// scale the y difference by the y fade
	always_comb begin
		diffy = {x1_s5[18], x1_s5} - {x0_s5[18], x0_s5};
		prody = $signed({1'b0, sy_s5}) * diffy;
	end

	// advance stage 6
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
		end else begin
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		prody_s6 <= prody;
		x0_s6    <= x0_s5;
	end

	// final blend and saturate to plus or minus one
	always_comb begin
		v = 36'(x0_s6) + ((prody_s6 + 36'sd8192) >>> FRAC_W);
		if (v > 36'sd16384) begin
			v_sat = NOISE_W'(ONE_Q14);
		end else if (v < -36'sd16384) begin
			v_sat = -NOISE_W'(ONE_Q14);
		end else begin
			v_sat = v[NOISE_W-1:0];
		end
	end

	// drive the result strobe and value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		noise_q <= v_sat;
	end

	assign done        = done_q;
	assign noise_value = noise_q;

`ifndef SYNTHESIS
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> ##6 done)
		else $error("pixel request did not reach the output on time");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (noise_value <= 16'sd16384 && noise_value >= -16'sd16384))
		else $error("noise value out of range");

	a_fade: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> (int'(sx_s3) <= ONE_Q14 && int'(sy_s3) <= ONE_Q14))
		else $error("fade above one");
`endif

endmodule
`default_nettype wire

### sim/tb.sv
// ---------------------------------------------------------------------------
// tb: self-checking bench for gradient_noise_pixel
// Loads every lattice corner, runs directed pixels and gradient writes, then
// random phases at several cell sizes. A local model predicts each noise value
// at acceptance and the monitor compares every done strobe against it.
// ---------------------------------------------------------------------------
module tb;
	import gnp_pkg::*;

	localparam int CORNER_COLS = GRID_COLS + 1;
	localparam int CORNER_ROWS = GRID_ROWS + 1;
	localparam int TABLE_DEPTH = CORNER_COLS * CORNER_ROWS;
	localparam int SETTLE      = 12;
	localparam int PHASE_REQS  = 55;
	localparam int NUM_PHASES  = 9;

	typedef enum logic [1:0] {
		ACT_REQ,
		ACT_CFG,
		ACT_DRAIN
	} act_t;

	typedef struct {
		act_t                act;
		kind_t               kind;
		logic [PIX_W-1:0]    px;
		logic [PIX_W-1:0]    py;
		logic [CORNER_W-1:0] col;
		logic [CORNER_W-1:0] row;
		grad_t               code;
		logic [CFG_W-1:0]    cfg;
		bit                  may_idle;
	} pend_t;

	logic                       clk         = 1'b0;
	logic                       arst_n      = 1'b0;
	logic                       start       = 1'b0;
	logic                       busy;
	logic                       kind        = 1'b0;
	logic [PIX_W-1:0]           pixel_x     = '0;
	logic [PIX_W-1:0]           pixel_y     = '0;
	logic [CORNER_W-1:0]        corner_col  = '0;
	logic [CORNER_W-1:0]        corner_row  = '0;
	logic [1:0]                 grad_code   = '0;
	logic                       cfg_write   = 1'b0;
	logic [CFG_W-1:0]           cfg_data    = '0;
	logic                       done;
	logic signed [NOISE_W-1:0]  noise_value;

	// model state and bookkeeping
	grad_t                      grad_mem [0:TABLE_DEPTH-1];
	logic [CFG_W-1:0]           cell_log2_q = CELL_LOG2_RESET;
	logic signed [NOISE_W-1:0]  noise_due [$];
	pend_t                      req_queue [$];
	pend_t                      nxt;
	logic signed [NOISE_W-1:0]  want;
	bit                         take;
	bit                         go_start;
	bit                         go_cfg;
	int                         quiet       = 0;
	int                         errors      = 0;
	int                         checked     = 0;
	int                         grad_writes = 0;
	int                         off_grid    = 0;
	int                         cfg_writes  = 0;

	gradient_noise_pixel i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.kind        (kind),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.corner_col  (corner_col),
		.corner_row  (corner_row),
		.grad_code   (grad_code),
		.cfg_write   (cfg_write),
		.cfg_data    (cfg_data),
		.done        (done),
		.noise_value (noise_value)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// quintic fade of k/2^lg, rounded half up to Q1.14
	function automatic longint fade_q14(int unsigned k, int unsigned lg);
		longint unsigned kk;
		longint unsigned n;
		longint unsigned poly;
		longint unsigned num;
		kk   = k;
		n    = 64'd1 << lg;
		poly = 64'd6 * kk * kk + 64'd10 * n * n - 64'd15 * kk * n;
		num  = kk * kk * kk * poly;
		return longint'(((num << FRAC_W) + (64'd1 << (5 * lg - 1))) >> (5 * lg));
	endfunction

	function automatic longint grad_dot(grad_t g, longint dx, longint dy);
		longint gx;
		longint gy;
		gx = (g == GRAD_PP || g == GRAD_PN) ? 1 : -1;
		gy = (g == GRAD_PP || g == GRAD_NP) ? 1 : -1;
		return gx * dx + gy * dy;
	endfunction

	// linear blend with the product rounded half up toward plus infinity
	function automatic longint mix(longint a, longint b, longint s);
		longint d;
		d = s * (b - a) + ONE_Q14 / 2;
		return a + (d >>> FRAC_W);
	endfunction

	function automatic logic signed [NOISE_W-1:0] noise_at(logic [PIX_W-1:0] px,
			logic [PIX_W-1:0] py);
		int unsigned lg;
		int unsigned kx;
		int unsigned ky;
		int unsigned cx;
		int unsigned cy;
		longint      fx;
		longint      fy;
		longint      sx;
		longint      sy;
		longint      x0;
		longint      x1;
		longint      v;
		lg = cell_log2_q;
		if (lg < CELL_LOG2_MIN) lg = CELL_LOG2_MIN;
		if (lg > CELL_LOG2_MAX) lg = CELL_LOG2_MAX;
		kx = px & ((1 << lg) - 1);
		ky = py & ((1 << lg) - 1);
		cx = px >> lg;
		cy = py >> lg;
		// clamp cells past the grid, keep the fraction
		if (cx > GRID_COLS - 1) cx = GRID_COLS - 1;
		if (cy > GRID_ROWS - 1) cy = GRID_ROWS - 1;
		fx = longint'(kx) << (FRAC_W - lg);
		fy = longint'(ky) << (FRAC_W - lg);
		sx = fade_q14(kx, lg);
		sy = fade_q14(ky, lg);
		x0 = mix(grad_dot(grad_mem[cy * CORNER_COLS + cx], fx, fy),
			grad_dot(grad_mem[cy * CORNER_COLS + cx + 1], fx - ONE_Q14, fy), sx);
		x1 = mix(grad_dot(grad_mem[(cy + 1) * CORNER_COLS + cx], fx, fy - ONE_Q14),
			grad_dot(grad_mem[(cy + 1) * CORNER_COLS + cx + 1], fx - ONE_Q14,
			fy - ONE_Q14), sx);
		v = mix(x0, x1, sy);
		if (v > ONE_Q14) v = ONE_Q14;
		if (v < -ONE_Q14) v = -ONE_Q14;
		return v[NOISE_W-1:0];
	endfunction

	function automatic pend_t pixel_req(int x, int y, bit may_idle);
		pend_t p;
		p.act      = ACT_REQ;
		p.kind     = KIND_PIXEL;
		p.px       = x[PIX_W-1:0];
		p.py       = y[PIX_W-1:0];
		p.col      = CORNER_W'($urandom_range(31));
		p.row      = CORNER_W'($urandom_range(31));
		p.code     = grad_t'($urandom_range(3));
		p.cfg      = '0;
		p.may_idle = may_idle;
		return p;
	endfunction

	function automatic pend_t write_req(int c, int r, grad_t g, bit may_idle);
		pend_t p;
		p.act      = ACT_REQ;
		p.kind     = KIND_WRITE;
		p.px       = PIX_W'($urandom_range(4095));
		p.py       = PIX_W'($urandom_range(4095));
		p.col      = c[CORNER_W-1:0];
		p.row      = r[CORNER_W-1:0];
		p.code     = g;
		p.cfg      = '0;
		p.may_idle = may_idle;
		return p;
	endfunction

	function automatic pend_t marker(act_t act, logic [CFG_W-1:0] val);
		pend_t p;
		p          = pixel_req(0, 0, 1'b0);
		p.act      = act;
		p.cfg      = val;
		return p;
	endfunction

	// pick a coordinate: anywhere, inside the grid, or on a cell edge
	function automatic int pick_coord(int lg);
		int pick;
		int lim;
		pick = $urandom_range(99);
		lim  = (GRID_COLS << lg) - 1;
		if (lim > 4095) lim = 4095;
		if (pick < 40) return $urandom_range(4095);
		if (pick < 85) return $urandom_range(lim);
		return ($urandom_range(lim) & ~((1 << lg) - 1))
			| ($urandom_range(1) ? (1 << lg) - 1 : 0);
	endfunction

	task automatic add_random(int lg, bit may_idle);
		int c;
		int r;
		if ($urandom_range(99) < 80) begin
			req_queue.push_back(pixel_req(pick_coord(lg), pick_coord(lg), may_idle));
		end else begin
			if ($urandom_range(99) < 85) begin
				c = $urandom_range(GRID_COLS);
				r = $urandom_range(GRID_ROWS);
			end else begin
				c = $urandom_range(31);
				r = $urandom_range(31);
			end
			req_queue.push_back(write_req(c, r, grad_t'($urandom_range(3)), may_idle));
		end
	endtask

	// drive requests and config writes, update the model on acceptance
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start     <= 1'b0;
			cfg_write <= 1'b0;
		end else begin
			if (cfg_write) begin
				cell_log2_q = cfg_data;
				cfg_writes++;
			end
			take = start && !busy;
			if (take) begin
				if (kind == KIND_WRITE) begin
					if (corner_col <= GRID_COLS && corner_row <= GRID_ROWS) begin
						grad_mem[corner_row * CORNER_COLS + corner_col] = grad_t'(grad_code);
						grad_writes++;
					end else begin
						off_grid++;
					end
				end else begin
					noise_due.push_back(noise_at(pixel_x, pixel_y));
				end
			end
			quiet = (take || noise_due.size() != 0) ? 0 : quiet + 1;
			if (quiet > 1000) quiet = 1000;
			// hold a request that was not taken
			if (!(start && !take)) begin
				go_start = 1'b0;
				go_cfg   = 1'b0;
				if (req_queue.size() != 0) begin
					nxt = req_queue[0];
					case (nxt.act)
						ACT_REQ: begin
							if (!(nxt.may_idle && $urandom_range(99) < 37)) begin
								void'(req_queue.pop_front());
								go_start   = 1'b1;
								kind       <= nxt.kind;
								pixel_x    <= nxt.px;
								pixel_y    <= nxt.py;
								corner_col <= nxt.col;
								corner_row <= nxt.row;
								grad_code  <= nxt.code;
							end
						end
						ACT_CFG: begin
							if (quiet >= SETTLE) begin
								void'(req_queue.pop_front());
								go_cfg   = 1'b1;
								cfg_data <= nxt.cfg;
							end
						end
						default: begin
							if (quiet >= SETTLE) void'(req_queue.pop_front());
						end
					endcase
				end
				start     <= go_start;
				cfg_write <= go_cfg;
			end
		end
	end

	// check each result against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (noise_due.size() == 0) begin
				$error("noise_value: unexpected result, actual %0d", noise_value);
				errors++;
			end else begin
				want = noise_due.pop_front();
				if (noise_value !== want) begin
					$error("noise_value: expected %0d, actual %0d", want, noise_value);
					errors++;
				end
				checked++;
			end
		end
	end

	initial begin
		logic [CFG_W-1:0] phase_cfg [0:NUM_PHASES-1];
		int               lg;
		phase_cfg = '{CELL_LOG2_MIN, CELL_LOG2_MAX, 4'd0, 4'd15, 4'd3, 4'd9, 4'd5, 4'd7,
			CFG_W'($urandom_range(15))};

		// load every corner before any pixel
		for (int r = 0; r <= GRID_ROWS; r++) begin
			for (int c = 0; c <= GRID_COLS; c++) begin
				req_queue.push_back(write_req(c, r, grad_t'($urandom_range(3)), 1'b1));
			end
		end

		// directed: coordinate extremes, grid clamp, each gradient, ignored writes
		req_queue.push_back(pixel_req(0, 0, 1'b1));
		req_queue.push_back(pixel_req(4095, 4095, 1'b1));
		req_queue.push_back(pixel_req(4095, 0, 1'b1));
		req_queue.push_back(pixel_req(0, 4095, 1'b1));
		req_queue.push_back(pixel_req(63, 63, 1'b1));
		req_queue.push_back(pixel_req(64, 64, 1'b1));
		req_queue.push_back(pixel_req(1023, 1023, 1'b1));
		req_queue.push_back(pixel_req(1024, 1000, 1'b1));
		for (int g = 0; g < 4; g++) begin
			req_queue.push_back(write_req(0, 0, grad_t'(g), 1'b1));
			req_queue.push_back(pixel_req(10, 20, 1'b1));
		end
		req_queue.push_back(write_req(GRID_COLS + 1, 0, GRAD_NN, 1'b1));
		req_queue.push_back(write_req(0, GRID_ROWS + 1, GRAD_NN, 1'b1));
		req_queue.push_back(write_req(31, 31, GRAD_PP, 1'b1));
		req_queue.push_back(write_req(GRID_COLS, GRID_ROWS, GRAD_NP, 1'b1));
		req_queue.push_back(pixel_req(4095, 4095, 1'b1));
		req_queue.push_back(pixel_req(32, 32, 1'b1));

		// random phases, one cell size each; phase 2 (from 0) adds no random idle gaps
		for (int p = 0; p < NUM_PHASES; p++) begin
			req_queue.push_back(marker(ACT_CFG, phase_cfg[p]));
			lg = phase_cfg[p];
			if (lg < CELL_LOG2_MIN) lg = CELL_LOG2_MIN;
			if (lg > CELL_LOG2_MAX) lg = CELL_LOG2_MAX;
			for (int i = 0; i < PHASE_REQS; i++) begin
				if (i == PHASE_REQS / 2) req_queue.push_back(marker(ACT_DRAIN, '0));
				add_random(lg, p != 2);
			end
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// drain the stimulus, then the outstanding results
		do @(posedge clk); while (req_queue.size() != 0 || start || cfg_write);
		do @(posedge clk); while (noise_due.size() != 0);
		repeat (SETTLE) @(posedge clk);

		$display("Checked %0d noise values over %0d cell size settings", checked, cfg_writes);
		$display("Applied %0d gradient writes, %0d outside the grid", grad_writes, off_grid);
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// stop a hung run
	initial begin
		#2000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
